// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the deque unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rn, expr, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
        else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define ASSERT_NEXT(lbl, ck, rn, trig, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Sizes, operation and status codes, and the structs shared by the deque.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 8;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                  shift_right;
        logic                  shift_left;
        logic                  push_rear;
        logic                  pop_rear;
        logic [DATA_WIDTH-1:0] value;
    } cell_cmd_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] read_value;
        status_t    status;
        logic       is_empty;
        logic [4:0] fill_count;
    } result_t;

endpackage

`default_nettype wire

// ===== design/deq_cell.sv =====
// ----------------------------------------------------------------------------
// Deque cell
// One element slot of the chain: shifts toward either neighbor, takes a rear
// push when it is the first free slot, drops its element on a rear pop when it is the rear.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire deq_pkg::cell_cmd_t            cmd,
    input  wire logic [deq_pkg::DATA_WIDTH-1:0] left_data,
    input  wire logic                          left_valid,
    input  wire logic [deq_pkg::DATA_WIDTH-1:0] right_data,
    input  wire logic                          right_valid,
    output logic      [deq_pkg::DATA_WIDTH-1:0] data,
    output logic                               valid,
    output logic      [deq_pkg::DATA_WIDTH-1:0] rear_tap
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  is_rear;
    logic                  is_slot;

    // rear element: held here, nothing held to the right
    assign is_rear = valid_reg & ~right_valid;
    // first free slot: empty here, neighbor on the left occupied
    assign is_slot = ~valid_reg & left_valid;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (cmd.shift_right)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (cmd.shift_left)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (cmd.push_rear && is_slot)
        begin
            data_next  = cmd.value;
            valid_next = 1'b1;
        end
        else if (cmd.pop_rear && is_rear)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign valid    = valid_reg;
    assign rear_tap = is_rear ? data_reg : '0;

endmodule

`default_nettype wire

// ===== design/deq_result.sv =====
// ----------------------------------------------------------------------------
// Deque result stage
// Output register for result transactions; holds while the consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_result (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire deq_pkg::result_t result,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output deq_pkg::result_t      held,
    output logic                  busy
);
    import deq_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t held_reg;

    // busy: a result waits and the consumer does not take it this cycle
    assign busy = out_valid_reg & out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign held      = held_reg;

endmodule

`default_nettype wire

// ===== design/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque of byte elements held in a chain of cells, front at cell 0.
// ----------------------------------------------------------------------------
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_stall, op, push_value                | request
//   out     | out_valid, out_stall, read_value, status,         | result
//           | is_empty, fill_count                              |
//
// One transaction per cycle is accepted while in_stall is low; each gives its result
// in the next cycle, from one pass through the cell chain into the output register.
// Reset clears every cell's valid bit, the count and the output valid flag.
// A stalled result holds in the output register; input stalls only while a
// result waits and out_stall is high.
`default_nettype none

`include "assert_macros.svh"

module double_ended_queue_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [2:0]            op,
    input  wire logic [7:0]            push_value,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 read_value,
    output logic [1:0]                 status,
    output logic                       is_empty,
    output logic [4:0]                 fill_count
);
    import deq_pkg::*;

    logic                  in_fire;
    logic                  busy;
    logic                  full;
    logic                  empty;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [DATA_WIDTH-1:0] value;
    logic [DATA_WIDTH-1:0] rear_data;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DEPTH-1:0]      cell_valid;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
    cell_cmd_t             cmd;
    status_t               st;
    result_t               result;
    result_t               held;

    assign in_stall = busy;
    assign in_fire  = in_valid & ~busy;
    assign value    = DATA_WIDTH'(push_value);
    assign full     = cell_valid[DEPTH-1];
    assign empty    = ~cell_valid[0];

    // Rear element: the one cell flagged as last drives its data, others zero.
    always_comb
    begin
        rear_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_data = rear_data | cell_tap[i];
        end
    end

    // Decode the operation into a chain command, the next count, the read data and status.
    always_comb
    begin
        cmd             = '0;
        cmd.value       = value;
        count_next      = count_reg;
        rd_data         = '0;
        st              = ST_OK;
        case (op_t'(op))
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    cmd.shift_right = in_fire;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_REAR:
            begin
                if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    cmd.push_rear = in_fire;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_data        = cell_data[0];
                    cmd.shift_left = in_fire;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            OP_POP_REAR:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_data      = rear_data;
                    cmd.pop_rear = in_fire;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            OP_PEEK_FRONT:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_data = cell_data[0];
                end
            end
            OP_PEEK_REAR:
            begin
                if (empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    rd_data = rear_data;
                end
            end
            default:
            begin
                // unused codes: no state change, ok status
                st = ST_OK;
            end
        endcase
    end

    assign result.read_value = 8'(rd_data);
    assign result.status     = st;
    assign result.is_empty   = (count_next == '0);
    assign result.fill_count = 5'(count_next);

    // Advance the count only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            count_reg <= count_next;
        end
    end

    // Cell chain: cell 0 sees the incoming value on its left, the last cell
    // sees an empty neighbor on its right.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] l_data;
        logic                  l_valid;
        logic [DATA_WIDTH-1:0] r_data;
        logic                  r_valid;

        if (i == 0)
        begin : g_first
            assign l_data  = value;
            assign l_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        deq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .rear_tap    (cell_tap[i])
        );
    end

    deq_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .result    (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .held      (held),
        .busy      (busy)
    );

    assign read_value = held.read_value;
    assign status     = held.status;
    assign is_empty   = held.is_empty;
    assign fill_count = held.fill_count;

    // Occupied cells always form an unbroken run from the front.
    `ASSERT_ALWAYS(a_valid_run, clk, rst_n,
        (cell_valid & (cell_valid + DEPTH'(1))) == '0, "cell valid bits not contiguous")
    // Count agrees with the full flag of the last cell.
    `ASSERT_ALWAYS(a_full_count, clk, rst_n,
        full == (count_reg == CNT_W'(DEPTH)), "count and full flag disagree")
    // Count agrees with the empty flag of the first cell.
    `ASSERT_ALWAYS(a_empty_count, clk, rst_n,
        empty == (count_reg == '0), "count and empty flag disagree")
    // An accepted push into a non-full deque adds exactly one element.
    `ASSERT_NEXT(a_push_grow, clk, rst_n,
        in_fire && !full && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR),
        count_reg == $past(count_reg) + CNT_W'(1), "push did not grow count")

endmodule

`default_nettype wire
